// File: rtl/core/wbc_pkg.sv
`default_nettype none

package wbc_pkg;

   // Default capacities
   localparam int MAX_TEXT_DEF     = 256;
   localparam int MAX_WORDS_DEF    = 32;
   localparam int MAX_WORD_LEN_DEF = 32;

   // Character width
   localparam int CHAR_W = 8;

   // Request modes
   localparam logic [1:0] MODE_CLEAR = 2'd0;
   localparam logic [1:0] MODE_DICT  = 2'd1;
   localparam logic [1:0] MODE_TEXT  = 2'd2;

   // Status of the reachability pass, seen by the top level
   typedef struct packed {
      logic done;     // result cycle of the pass
      logic reached;  // position zero is reachable
   } pass_status_type;

   // Address bits for a store of the given depth (at least one)
   function automatic int addr_bits(input int depth);
      return (depth > 1) ? $clog2(depth) : 1;
   endfunction

endpackage

`default_nettype wire

// File: rtl/core/wbc_ram.sv
`default_nettype none

module wbc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                                   clock,
   input  wire logic                                   wr_en,
   input  wire logic [wbc_pkg::addr_bits(DEPTH)-1:0]   wr_addr,
   input  wire logic [WIDTH-1:0]                       wr_data,
   input  wire logic [wbc_pkg::addr_bits(DEPTH)-1:0]   rd_addr,
   output logic      [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // One write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

// File: rtl/core/wbc_search.sv
`default_nettype none

module wbc_search #(
   parameter int MAX_TEXT     = wbc_pkg::MAX_TEXT_DEF,
   parameter int MAX_WORDS    = wbc_pkg::MAX_WORDS_DEF,
   parameter int MAX_WORD_LEN = wbc_pkg::MAX_WORD_LEN_DEF,
   localparam int TW  = $clog2(MAX_TEXT + 1),
   localparam int TAW = wbc_pkg::addr_bits(MAX_TEXT),
   localparam int WCW = $clog2(MAX_WORDS + 1),
   localparam int WAW = wbc_pkg::addr_bits(MAX_WORDS),
   localparam int LW  = $clog2(MAX_WORD_LEN + 1),
   localparam int DAW = wbc_pkg::addr_bits(MAX_WORDS * MAX_WORD_LEN),
   localparam int DBW = $clog2(MAX_WORDS * MAX_WORD_LEN + 1)
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          go,
   input  wire logic [TW-1:0]                 text_len,
   input  wire logic [WCW-1:0]                word_count,
   output logic      [WAW-1:0]                wl_rd_addr,
   input  wire logic [LW-1:0]                 wl_rd_data,
   output logic      [DAW-1:0]                dict_rd_addr,
   input  wire logic [wbc_pkg::CHAR_W-1:0]    dict_rd_data,
   output logic      [TAW-1:0]                text_rd_addr,
   input  wire logic [wbc_pkg::CHAR_W-1:0]    text_rd_data,
   output logic                               reach_wr_en,
   output logic      [TW-1:0]                 reach_wr_addr,
   output logic                               reach_wr_data,
   output logic      [TW-1:0]                 reach_rd_addr,
   input  wire logic                          reach_rd_data,
   output logic                               busy,
   output wbc_pkg::pass_status_type           status
);

   localparam int SW = ((TW > LW) ? TW : LW) + 1;

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_INIT     = 4'd1;
   localparam logic [3:0] S_POS      = 4'd2;
   localparam logic [3:0] S_WORD_RD  = 4'd3;
   localparam logic [3:0] S_WORD_LEN = 4'd4;
   localparam logic [3:0] S_REACH    = 4'd5;
   localparam logic [3:0] S_CHAR_RD  = 4'd6;
   localparam logic [3:0] S_CHAR_CMP = 4'd7;
   localparam logic [3:0] S_FINISH   = 4'd8;
   localparam logic [3:0] S_RESULT   = 4'd9;

   logic [3:0]     state_ff, state_in;
   logic [TW-1:0]  i_ff, i_in;       // positions still to visit
   logic [WCW-1:0] w_ff, w_in;       // word under test
   logic [DBW-1:0] base_ff, base_in; // first dictionary entry of that word
   logic [LW-1:0]  len_ff, len_in;
   logic [LW-1:0]  k_ff, k_in;

   logic [TW-1:0]  pos;
   logic [SW-1:0]  remain;
   logic [SW-1:0]  reach_sum;
   logic [SW-1:0]  text_sum;
   logic [DBW-1:0] dict_sum;
   logic           len_fits;

   // Address arithmetic
   always_comb begin
      pos          = i_ff - TW'(1);
      remain       = SW'(text_len) - SW'(pos);
      reach_sum    = SW'(pos) + SW'(wl_rd_data);
      text_sum     = SW'(pos) + SW'(k_ff);
      dict_sum     = base_ff + DBW'(k_ff);
      len_fits     = (wl_rd_data != '0) && (SW'(wl_rd_data) <= remain);
      wl_rd_addr   = w_ff[WAW-1:0];
      dict_rd_addr = dict_sum[DAW-1:0];
      text_rd_addr = text_sum[TAW-1:0];
      reach_rd_addr = (state_ff == S_FINISH) ? '0 : reach_sum[TW-1:0];
   end

   // Pass sequencer
   always_comb begin
      state_in      = state_ff;
      i_in          = i_ff;
      w_in          = w_ff;
      base_in       = base_ff;
      len_in        = len_ff;
      k_in          = k_ff;
      reach_wr_en   = 1'b0;
      reach_wr_addr = pos;
      reach_wr_data = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (go) begin
               state_in = S_INIT;
            end
         end
         S_INIT: begin
            // end of text is always reachable
            reach_wr_en   = 1'b1;
            reach_wr_addr = text_len;
            reach_wr_data = 1'b1;
            i_in          = text_len;
            state_in      = S_POS;
         end
         S_POS: begin
            w_in    = '0;
            base_in = '0;
            state_in = (i_ff == '0) ? S_FINISH : S_WORD_RD;
         end
         S_WORD_RD: begin
            if (w_ff == word_count) begin
               // no word fits here
               reach_wr_en = 1'b1;
               i_in        = i_ff - TW'(1);
               state_in    = S_POS;
            end else begin
               state_in = S_WORD_LEN;
            end
         end
         S_WORD_LEN: begin
            len_in = wl_rd_data;
            if (len_fits) begin
               state_in = S_REACH;
            end else begin
               w_in     = w_ff + WCW'(1);
               base_in  = base_ff + DBW'(MAX_WORD_LEN);
               state_in = S_WORD_RD;
            end
         end
         S_REACH: begin
            k_in = '0;
            if (reach_rd_data) begin
               state_in = S_CHAR_RD;
            end else begin
               w_in     = w_ff + WCW'(1);
               base_in  = base_ff + DBW'(MAX_WORD_LEN);
               state_in = S_WORD_RD;
            end
         end
         S_CHAR_RD: begin
            state_in = S_CHAR_CMP;
         end
         S_CHAR_CMP: begin
            if (dict_rd_data != text_rd_data) begin
               w_in     = w_ff + WCW'(1);
               base_in  = base_ff + DBW'(MAX_WORD_LEN);
               state_in = S_WORD_RD;
            end else if (k_ff == len_ff - LW'(1)) begin
               // whole word matches and lands on a reachable position
               reach_wr_en   = 1'b1;
               reach_wr_data = 1'b1;
               i_in          = i_ff - TW'(1);
               state_in      = S_POS;
            end else begin
               k_in     = k_ff + LW'(1);
               state_in = S_CHAR_RD;
            end
         end
         S_FINISH: begin
            state_in = S_RESULT;
         end
         S_RESULT: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      i_ff    <= i_in;
      w_ff    <= w_in;
      base_ff <= base_in;
      len_ff  <= len_in;
      k_ff    <= k_in;
   end

   assign busy           = (state_ff != S_IDLE);
   assign status.done    = (state_ff == S_RESULT);
   assign status.reached = reach_rd_data;

   // Checks
   a_go_idle: assert property (@(posedge clock) disable iff (reset)
      go |-> (state_ff == S_IDLE))
      else $error("pass started while busy");

   a_reach_range: assert property (@(posedge clock) disable iff (reset)
      reach_wr_en |-> (reach_wr_addr <= text_len))
      else $error("reachability write beyond end of text");

   a_char_index: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CHAR_CMP) |-> (k_ff < len_ff))
      else $error("character index past word length");

   a_result_once: assert property (@(posedge clock) disable iff (reset)
      status.done |=> (state_ff == S_IDLE))
      else $error("result strobe not followed by idle");

endmodule

`default_nettype wire

// File: rtl/core/word_break_checker.sv
// Channel  Ports                                      Handshake
// -------  -----------------------------------------  -------------------------------
// request  req_mode, req_symbol, req_last             start && !busy accepts a word
// result   rsp_breakable, rsp_overflow                rsp_valid, one cycle, no stall
//
// Clear, dictionary and text words leave busy low.
// A text word with req_last starts the pass: from the end of the text back to
// zero it tries each stored word at each position, one character at a time,
// through the single read port of the character and reachability memories.
// The result shows on rsp_valid in the last cycle of the pass.
// Synchronous reset clears counters and flags; no memory clearing pass.
// The receiver cannot stall; results are never held.
`default_nettype none

module word_break_checker #(
   parameter int MAX_TEXT     = wbc_pkg::MAX_TEXT_DEF,
   parameter int MAX_WORDS    = wbc_pkg::MAX_WORDS_DEF,
   parameter int MAX_WORD_LEN = wbc_pkg::MAX_WORD_LEN_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   output logic                             busy,
   input  wire logic [1:0]                  req_mode,
   input  wire logic [wbc_pkg::CHAR_W-1:0]  req_symbol,
   input  wire logic                        req_last,
   output logic                             rsp_valid,
   output logic                             rsp_breakable,
   output logic                             rsp_overflow
);

   localparam int TW  = $clog2(MAX_TEXT + 1);
   localparam int TAW = wbc_pkg::addr_bits(MAX_TEXT);
   localparam int WCW = $clog2(MAX_WORDS + 1);
   localparam int WAW = wbc_pkg::addr_bits(MAX_WORDS);
   localparam int LW  = $clog2(MAX_WORD_LEN + 1);
   localparam int DAW = wbc_pkg::addr_bits(MAX_WORDS * MAX_WORD_LEN);
   localparam int DBW = $clog2(MAX_WORDS * MAX_WORD_LEN + 1);

   logic [WCW-1:0] word_count_ff, word_count_in;
   logic [LW-1:0]  cur_len_ff, cur_len_in;
   logic [DBW-1:0] wbase_ff, wbase_in;   // dictionary base of word in progress
   logic [TW-1:0]  text_len_ff, text_len_in;
   logic           overflow_ff, overflow_in;

   logic           accept;
   logic           pass_go;
   logic           search_busy;
   logic [LW-1:0]  new_len;
   logic [DBW-1:0] dict_sum;
   logic           dict_wr_en;
   logic           wl_wr_en;
   logic           text_wr_en;

   wbc_pkg::pass_status_type pass_status;

   logic [WAW-1:0]                wl_rd_addr;
   logic [LW-1:0]                 wl_rd_data;
   logic [DAW-1:0]                dict_rd_addr;
   logic [wbc_pkg::CHAR_W-1:0]    dict_rd_data;
   logic [TAW-1:0]                text_rd_addr;
   logic [wbc_pkg::CHAR_W-1:0]    text_rd_data;
   logic                          reach_wr_en;
   logic [TW-1:0]                 reach_wr_addr;
   logic                          reach_wr_data;
   logic [TW-1:0]                 reach_rd_addr;
   logic                          reach_rd_data;

   assign accept   = start && !busy;
   assign busy     = search_busy;
   assign dict_sum = wbase_ff + DBW'(cur_len_ff);

   // Clearing and loading of dictionary and text
   always_comb begin
      word_count_in = word_count_ff;
      cur_len_in    = cur_len_ff;
      wbase_in      = wbase_ff;
      text_len_in   = text_len_ff;
      overflow_in   = overflow_ff;
      new_len       = cur_len_ff;
      dict_wr_en    = 1'b0;
      wl_wr_en      = 1'b0;
      text_wr_en    = 1'b0;
      pass_go       = 1'b0;
      if (accept) begin
         case (req_mode)
            wbc_pkg::MODE_CLEAR: begin
               word_count_in = '0;
               cur_len_in    = '0;
               wbase_in      = '0;
               text_len_in   = '0;
               overflow_in   = 1'b0;
            end
            wbc_pkg::MODE_DICT: begin
               if (word_count_ff >= WCW'(MAX_WORDS) || cur_len_ff >= LW'(MAX_WORD_LEN)) begin
                  overflow_in = 1'b1;
               end else begin
                  dict_wr_en = 1'b1;
                  new_len    = cur_len_ff + LW'(1);
               end
               cur_len_in = new_len;
               if (req_last) begin
                  // commit the word in progress
                  if (new_len != '0 && word_count_ff < WCW'(MAX_WORDS)) begin
                     wl_wr_en      = 1'b1;
                     word_count_in = word_count_ff + WCW'(1);
                     wbase_in      = wbase_ff + DBW'(MAX_WORD_LEN);
                  end
                  cur_len_in = '0;
               end
            end
            wbc_pkg::MODE_TEXT: begin
               if (text_len_ff >= TW'(MAX_TEXT)) begin
                  overflow_in = 1'b1;
               end else begin
                  text_wr_en  = 1'b1;
                  text_len_in = text_len_ff + TW'(1);
               end
               pass_go = req_last;
            end
            default: begin
            end
         endcase
      end
      // text is emptied once its result goes out
      if (pass_status.done) begin
         text_len_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_count_ff <= '0;
         cur_len_ff    <= '0;
         wbase_ff      <= '0;
         text_len_ff   <= '0;
         overflow_ff   <= 1'b0;
      end else begin
         word_count_ff <= word_count_in;
         cur_len_ff    <= cur_len_in;
         wbase_ff      <= wbase_in;
         text_len_ff   <= text_len_in;
         overflow_ff   <= overflow_in;
      end
   end

   // Memories
   wbc_ram #(
      .WIDTH (wbc_pkg::CHAR_W),
      .DEPTH (MAX_WORDS * MAX_WORD_LEN)
   ) u_dict_ram (
      .clock   (clock),
      .wr_en   (dict_wr_en),
      .wr_addr (dict_sum[DAW-1:0]),
      .wr_data (req_symbol),
      .rd_addr (dict_rd_addr),
      .rd_data (dict_rd_data)
   );

   wbc_ram #(
      .WIDTH (LW),
      .DEPTH (MAX_WORDS)
   ) u_wlen_ram (
      .clock   (clock),
      .wr_en   (wl_wr_en),
      .wr_addr (word_count_ff[WAW-1:0]),
      .wr_data (new_len),
      .rd_addr (wl_rd_addr),
      .rd_data (wl_rd_data)
   );

   wbc_ram #(
      .WIDTH (wbc_pkg::CHAR_W),
      .DEPTH (MAX_TEXT)
   ) u_text_ram (
      .clock   (clock),
      .wr_en   (text_wr_en),
      .wr_addr (text_len_ff[TAW-1:0]),
      .wr_data (req_symbol),
      .rd_addr (text_rd_addr),
      .rd_data (text_rd_data)
   );

   wbc_ram #(
      .WIDTH (1),
      .DEPTH (MAX_TEXT + 1)
   ) u_reach_ram (
      .clock   (clock),
      .wr_en   (reach_wr_en),
      .wr_addr (reach_wr_addr),
      .wr_data (reach_wr_data),
      .rd_addr (reach_rd_addr),
      .rd_data (reach_rd_data)
   );

   // Reachability pass
   wbc_search #(
      .MAX_TEXT     (MAX_TEXT),
      .MAX_WORDS    (MAX_WORDS),
      .MAX_WORD_LEN (MAX_WORD_LEN)
   ) u_search (
      .clock         (clock),
      .reset         (reset),
      .go            (pass_go),
      .text_len      (text_len_ff),
      .word_count    (word_count_ff),
      .wl_rd_addr    (wl_rd_addr),
      .wl_rd_data    (wl_rd_data),
      .dict_rd_addr  (dict_rd_addr),
      .dict_rd_data  (dict_rd_data),
      .text_rd_addr  (text_rd_addr),
      .text_rd_data  (text_rd_data),
      .reach_wr_en   (reach_wr_en),
      .reach_wr_addr (reach_wr_addr),
      .reach_wr_data (reach_wr_data),
      .reach_rd_addr (reach_rd_addr),
      .reach_rd_data (reach_rd_data),
      .busy          (search_busy),
      .status        (pass_status)
   );

   // Result
   assign rsp_valid     = pass_status.done;
   assign rsp_breakable = pass_status.reached & ~overflow_ff;
   assign rsp_overflow  = overflow_ff;

endmodule

`default_nettype wire

// File: tb/sv/tb_word_break_checker.sv
`timescale 1ns / 1ps

module tb_word_break_checker;

   localparam int TEXT_CAP = wbc_pkg::MAX_TEXT_DEF;
   localparam int WORD_CAP = wbc_pkg::MAX_WORDS_DEF;
   localparam int WLEN_CAP = wbc_pkg::MAX_WORD_LEN_DEF;
   localparam int CW = wbc_pkg::CHAR_W;
   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam int RANDOM_WORDS = 540;
   localparam int QUIET_WORDS = 300;
   localparam int ENTRY_LEN_MAX = 4;
   localparam int TAIL_CYCLES = 64;
   localparam longint TIMEOUT_NS = 64'd20_000_000;

   typedef struct packed {
      logic breakable;
      logic overflow;
   } verdict_type;

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   logic [1:0]        req_mode;
   logic [CW-1:0]     req_symbol;
   logic              req_last;
   logic              rsp_valid;
   logic              rsp_breakable;
   logic              rsp_overflow;

   // shadow copy of the block state
   logic [CW-1:0]     sh_dict [WORD_CAP][WLEN_CAP];
   int                sh_entry_len [WORD_CAP];
   int                sh_entries = 0;
   int                sh_cur_len = 0;
   logic [CW-1:0]     sh_text [TEXT_CAP];
   int                sh_text_len = 0;
   bit                sh_overflow = 1'b0;

   verdict_type       expected_verdicts [$];
   int unsigned       mismatches = 0;
   int unsigned       words_sent = 0;
   bit                gaps_on = 1'b0;

   // stimulus side: current entry list, its alphabet and the text being built
   logic [CW-1:0]     lex_char [WORD_CAP][WLEN_CAP+1];
   int                lex_len [WORD_CAP];
   int                lex_n = 0;
   logic [CW-1:0]     alpha [3];
   logic [CW-1:0]     phrase [$];

   word_break_checker dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_mode      (req_mode),
      .req_symbol    (req_symbol),
      .req_last      (req_last),
      .rsp_valid     (rsp_valid),
      .rsp_breakable (rsp_breakable),
      .rsp_overflow  (rsp_overflow)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   // backward reachability over the stored text
   function automatic bit text_splits();
      bit reach [TEXT_CAP+1];
      int p;
      int w;
      int k;
      bit hit;
      for (p = 0; p <= TEXT_CAP; p++) reach[p] = 1'b0;
      reach[sh_text_len] = 1'b1;
      for (p = sh_text_len - 1; p >= 0; p--) begin
         for (w = 0; w < sh_entries && !reach[p]; w++) begin
            if (sh_entry_len[w] <= sh_text_len - p) begin
               hit = 1'b1;
               for (k = 0; k < sh_entry_len[w]; k++)
                  if (sh_dict[w][k] != sh_text[p + k]) hit = 1'b0;
               if (hit && reach[p + sh_entry_len[w]]) reach[p] = 1'b1;
            end
         end
      end
      return reach[0];
   endfunction

   // apply one accepted word to the shadow state, queue any verdict it causes
   function automatic void absorb_word(logic [1:0] mode, logic [CW-1:0] sym, logic lst);
      verdict_type v;
      case (mode)
         wbc_pkg::MODE_CLEAR: begin
            sh_entries = 0;
            sh_cur_len = 0;
            sh_text_len = 0;
            sh_overflow = 1'b0;
         end
         wbc_pkg::MODE_DICT: begin
            if (sh_entries >= WORD_CAP || sh_cur_len >= WLEN_CAP) begin
               sh_overflow = 1'b1;
            end else begin
               sh_dict[sh_entries][sh_cur_len] = sym;
               sh_cur_len++;
            end
            // entry is kept even if some characters were dropped
            if (lst) begin
               if (sh_cur_len > 0 && sh_entries < WORD_CAP) begin
                  sh_entry_len[sh_entries] = sh_cur_len;
                  sh_entries++;
               end
               sh_cur_len = 0;
            end
         end
         wbc_pkg::MODE_TEXT: begin
            if (sh_text_len >= TEXT_CAP) begin
               sh_overflow = 1'b1;
            end else begin
               sh_text[sh_text_len] = sym;
               sh_text_len++;
            end
            if (lst) begin
               v.overflow = sh_overflow;
               v.breakable = text_splits() && !sh_overflow;
               expected_verdicts.push_back(v);
               sh_text_len = 0;
            end
         end
         default: ;
      endcase
   endfunction

   // send one word; start stays high across back-to-back words
   task automatic send_word(input logic [1:0] mode, input logic [CW-1:0] sym,
                            input logic lst);
      int gap;
      if (gaps_on && $urandom_range(99) < 38) begin
         gap = $urandom_range(2, 1);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_mode <= mode;
      req_symbol <= sym;
      req_last <= lst;
      @(posedge clock);
      while (busy) @(posedge clock);
      absorb_word(mode, sym, lst);
      if (mode != MODE_UNUSED) words_sent++;
   endtask

   // hold off until every verdict has come back
   task automatic drain();
      start <= 1'b0;
      do @(posedge clock);
      while (expected_verdicts.size() != 0 || busy);
   endtask

   function automatic void make_lexicon(int n, int max_len);
      for (int a = 0; a < 3; a++) alpha[a] = CW'($urandom_range(255));
      lex_n = n;
      for (int w = 0; w < n; w++) begin
         lex_len[w] = $urandom_range(max_len, 1);
         for (int k = 0; k < lex_len[w]; k++) lex_char[w][k] = alpha[$urandom_range(2)];
      end
   endfunction

   task automatic load_lexicon();
      for (int w = 0; w < lex_n; w++)
         for (int k = 0; k < lex_len[w]; k++)
            send_word(wbc_pkg::MODE_DICT, lex_char[w][k], k == lex_len[w] - 1);
   endtask

   function automatic void append_entry(int w);
      for (int k = 0; k < lex_len[w]; k++) phrase.push_back(lex_char[w][k]);
   endfunction

   // text made of entries, optionally broken by one edit
   function automatic void compose_phrase(int pieces, bit corrupt);
      int at;
      int pick;
      phrase.delete();
      repeat (pieces) append_entry($urandom_range(lex_n - 1));
      if (corrupt) begin
         at = $urandom_range(phrase.size() - 1);
         pick = $urandom_range(2);
         if (pick == 0) phrase[at] = alpha[$urandom_range(2)];
         else if (pick == 1) phrase[at] = CW'($urandom_range(255));
         else if (phrase.size() > 1) phrase.delete(at);
         else phrase.push_back(alpha[0]);
      end
   endfunction

   task automatic send_phrase();
      for (int i = 0; i < phrase.size(); i++)
         send_word(wbc_pkg::MODE_TEXT, phrase[i], i == phrase.size() - 1);
   endtask

   // field extremes, ignored mode, empty dictionary, clear
   task automatic test_basics();
      send_word(wbc_pkg::MODE_TEXT, 8'h00, 1'b1);
      send_word(MODE_UNUSED, 8'hFF, 1'b1);
      send_word(wbc_pkg::MODE_DICT, 8'h00, 1'b1);
      send_word(wbc_pkg::MODE_DICT, 8'hFF, 1'b0);
      send_word(wbc_pkg::MODE_DICT, 8'h80, 1'b1);
      send_word(wbc_pkg::MODE_DICT, 8'h7F, 1'b0);
      send_word(MODE_UNUSED, 8'h00, 1'b0);
      send_word(wbc_pkg::MODE_DICT, 8'h01, 1'b1);
      send_word(wbc_pkg::MODE_TEXT, 8'hFF, 1'b0);
      send_word(wbc_pkg::MODE_TEXT, 8'h80, 1'b0);
      send_word(wbc_pkg::MODE_TEXT, 8'h00, 1'b0);
      send_word(MODE_UNUSED, 8'hAA, 1'b1);
      send_word(wbc_pkg::MODE_TEXT, 8'h7F, 1'b0);
      send_word(wbc_pkg::MODE_TEXT, 8'h01, 1'b1);
      send_word(wbc_pkg::MODE_TEXT, 8'hFF, 1'b1);
      send_word(wbc_pkg::MODE_TEXT, 8'h00, 1'b0);
      send_word(wbc_pkg::MODE_TEXT, 8'h00, 1'b1);
      send_word(wbc_pkg::MODE_CLEAR, 8'h55, 1'b1);
      send_word(wbc_pkg::MODE_TEXT, 8'h00, 1'b1);
   endtask

   // entry one character too long, then exactly at the length limit
   task automatic test_long_word();
      send_word(wbc_pkg::MODE_CLEAR, CW'($urandom_range(255)), 1'($urandom_range(1)));
      lex_n = 1;
      lex_len[0] = WLEN_CAP + 1;
      for (int k = 0; k <= WLEN_CAP; k++) lex_char[0][k] = CW'($urandom_range(255));
      load_lexicon();
      lex_len[0] = WLEN_CAP;
      compose_phrase(1, 1'b0);
      send_phrase();
      send_word(wbc_pkg::MODE_CLEAR, CW'($urandom_range(255)), 1'($urandom_range(1)));
      load_lexicon();
      compose_phrase(2, 1'b0);
      send_phrase();
      compose_phrase(1, 1'b1);
      send_phrase();
   endtask

   // full dictionary, then characters past the entry limit
   task automatic test_word_capacity();
      send_word(wbc_pkg::MODE_CLEAR, CW'($urandom_range(255)), 1'($urandom_range(1)));
      make_lexicon(WORD_CAP, 2);
      load_lexicon();
      compose_phrase(8, 1'b0);
      send_phrase();
      send_word(wbc_pkg::MODE_DICT, CW'($urandom_range(255)), 1'b0);
      send_word(wbc_pkg::MODE_DICT, CW'($urandom_range(255)), 1'b1);
      compose_phrase(2, 1'b0);
      send_phrase();
   endtask

   // text exactly full, text too long, overflow held until clear
   task automatic test_text_capacity();
      send_word(wbc_pkg::MODE_CLEAR, CW'($urandom_range(255)), 1'($urandom_range(1)));
      lex_n = 2;
      lex_len[0] = 1;
      lex_len[1] = 3;
      for (int k = 0; k < 3; k++) begin
         lex_char[0][k] = CW'($urandom_range(255));
         lex_char[1][k] = CW'($urandom_range(255));
      end
      load_lexicon();
      phrase.delete();
      while (phrase.size() < TEXT_CAP)
         append_entry((TEXT_CAP - phrase.size() >= 3 && $urandom_range(1)) ? 1 : 0);
      send_phrase();
      repeat (4) phrase.push_back(lex_char[0][0]);
      send_phrase();
      compose_phrase(2, 1'b0);
      send_phrase();
      send_word(wbc_pkg::MODE_CLEAR, CW'($urandom_range(255)), 1'($urandom_range(1)));
      compose_phrase(1, 1'b0);
      send_phrase();
   endtask

   // mostly well-formed dictionary/text rounds, some noise
   task automatic random_round();
      int pick;
      pick = $urandom_range(99);
      if (pick < 12) begin
         repeat ($urandom_range(12, 1))
            send_word(2'($urandom_range(3)), CW'($urandom_range(255)),
                      1'($urandom_range(1)));
      end else begin
         if (pick < 78 || lex_n == 0) begin
            send_word(wbc_pkg::MODE_CLEAR, CW'($urandom_range(255)),
                      1'($urandom_range(1)));
            make_lexicon($urandom_range(6, 1), ENTRY_LEN_MAX);
            load_lexicon();
         end else if (pick < 88) begin
            // extra entries on top of what is held
            make_lexicon($urandom_range(6, 1), ENTRY_LEN_MAX);
            load_lexicon();
         end
         repeat ($urandom_range(4, 1)) begin
            compose_phrase($urandom_range(5, 1), $urandom_range(99) < 30);
            send_phrase();
         end
      end
   endtask

   task automatic test_random();
      words_sent = 0;
      gaps_on = 1'b0;
      while (words_sent < RANDOM_WORDS) begin
         if (words_sent >= QUIET_WORDS) gaps_on = 1'b1;
         random_round();
         if ($urandom_range(99) < 8) drain();
      end
   endtask

   // verdict checker
   always @(posedge clock) begin
      verdict_type want;
      if (!reset && rsp_valid) begin
         if (expected_verdicts.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected result, expected none, got breakable=%0b overflow=%0b",
                     $time, rsp_breakable, rsp_overflow);
         end else begin
            want = expected_verdicts.pop_front();
            if (rsp_breakable !== want.breakable) begin
               mismatches++;
               $display("%0t: breakable expected %0b, got %0b",
                        $time, want.breakable, rsp_breakable);
            end
            if (rsp_overflow !== want.overflow) begin
               mismatches++;
               $display("%0t: overflow expected %0b, got %0b",
                        $time, want.overflow, rsp_overflow);
            end
         end
      end
   end

   initial begin
      reset <= 1'b1;
      start <= 1'b0;
      req_mode <= wbc_pkg::MODE_CLEAR;
      req_symbol <= '0;
      req_last <= 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      gaps_on = 1'b1;
      test_basics();
      drain();
      test_long_word();
      drain();
      test_word_capacity();
      drain();
      test_text_capacity();
      drain();
      test_random();
      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("** word_break_checker: PASSED **");
      else
         $display("** word_break_checker: FAILED **");
      $finish;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("** word_break_checker: FAILED **");
      $finish;
   end

endmodule

// File: sim.f
rtl/core/wbc_pkg.sv
rtl/core/wbc_ram.sv
rtl/core/wbc_search.sv
rtl/core/word_break_checker.sv
tb/sv/tb_word_break_checker.sv
